FILE: hdl/srrw_pkg.sv
// shared types and constants for the selective-repeat receiver window
package srrw_pkg;

  // fixed field widths of the frame and result ports
  localparam int PEER_W     = 4;
  localparam int DEST_W     = 8;
  localparam int SEQ_W      = 8;
  localparam int WIN_W      = 4;
  localparam int PAY_PORT_W = 64;

  // operand width of the modular unit, wide enough to hold a 256 modulus
  localparam int VAL_W = 9;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECEIVER_ID  = 1'b0,
    REG_WINDOW_SLOTS = 1'b1
  } cfg_reg_t;

  // result kinds
  localparam logic KIND_DELIVERY = 1'b0;
  localparam logic KIND_ACK      = 1'b1;

  // reset value of the window size register
  localparam logic [WIN_W-1:0] WINDOW_SLOTS_RST = 4'd8;

  // modular unit operations
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] m;
  } alu_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] res;
    logic             wrap;
  } alu_rsp_t;

endpackage

FILE: hdl/srrw_modalu.sv
// shared modular add / subtract unit used by the window sequencer
module srrw_modalu
  import srrw_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [VAL_W:0]   sum;
  logic             sum_ge;
  logic [VAL_W-1:0] dif;
  logic             a_ge_b;

  // add with one conditional subtract of the modulus
  assign sum    = {1'b0, req.a} + {1'b0, req.b};
  assign sum_ge = (sum >= {1'b0, req.m});

  // subtract with one conditional add of the modulus
  assign dif    = req.a - req.b;
  assign a_ge_b = (req.a >= req.b);

  always_comb begin
    case (req.op)
      ALU_ADD: begin
        rsp.wrap = sum_ge;
        rsp.res  = sum_ge ? VAL_W'(sum - {1'b0, req.m}) : sum[VAL_W-1:0];
      end
      ALU_SUB: begin
        rsp.wrap = !a_ge_b;
        rsp.res  = a_ge_b ? dif : VAL_W'(dif + req.m);
      end
      default: begin
        rsp.wrap = 1'b0;
        rsp.res  = '0;
      end
    endcase
  end

endmodule

FILE: hdl/srrw_state_ram.sv
// per-sender window state memory with reset-cleared valid bits
module srrw_state_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_q_r;
  logic             rd_vld_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // valid bits, an entry never written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: hdl/srrw_slot_ram.sv
// payload slot memory, one row of slots per sender
module srrw_slot_ram #(
  parameter int AW = 7,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rd_data_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/srrw_ctrl.sv
// window sequencer: reduce, place, release and acknowledge one frame
module srrw_ctrl
  import srrw_pkg::*;
#(
  parameter int SEQ_SPACE    = 256,
  parameter int WINDOW_MAX   = 8,
  parameter int PAYLOAD_BITS = 64,
  parameter int SIDX_W       = 4,
  parameter int WSL_W        = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // frame taken this cycle
  input  logic                          go,
  input  logic [PEER_W-1:0]             src,
  input  logic [SEQ_W-1:0]              seq,
  input  logic [PAYLOAD_BITS-1:0]       pay,
  input  logic [WIN_W-1:0]              wnd,
  output logic                          busy,
  // window state memory
  output logic                          st_rd_en,
  output logic [SIDX_W-1:0]             st_rd_addr,
  input  logic [SEQ_W+WSL_W+WINDOW_MAX-1:0] st_rd_data,
  output logic                          st_wr_en,
  output logic [SIDX_W-1:0]             st_wr_addr,
  output logic [SEQ_W+WSL_W+WINDOW_MAX-1:0] st_wr_data,
  // payload slot memory
  output logic                          sl_rd_en,
  output logic [SIDX_W+WSL_W-1:0]       sl_rd_addr,
  input  logic [PAYLOAD_BITS-1:0]       sl_rd_data,
  output logic                          sl_wr_en,
  output logic [SIDX_W+WSL_W-1:0]       sl_wr_addr,
  output logic [PAYLOAD_BITS-1:0]       sl_wr_data,
  // result transaction
  output logic                          out_valid,
  output logic                          out_result_kind,
  output logic [PEER_W-1:0]             out_peer_id,
  output logic [SEQ_W-1:0]              out_ack_number,
  output logic [WIN_W-1:0]              out_advertised_window,
  output logic [PAY_PORT_W-1:0]         out_delivered_payload,
  output logic                          out_last_of_run
);

  localparam int ST_W = SEQ_W + WSL_W + WINDOW_MAX;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEQRED,
    S_LEN,
    S_BSRED,
    S_POS,
    S_SCAN_RD,
    S_SCAN_OUT,
    S_SCAN_NXT,
    S_WB,
    S_ACK
  } state_t;

  state_t                  state_r;
  logic [PEER_W-1:0]       src_r;
  logic [VAL_W-1:0]        x_r;
  logic [SEQ_W-1:0]        base_r;
  logic [WSL_W-1:0]        bslot_r;
  logic [WSL_W-1:0]        p_r;
  logic [SEQ_W-1:0]        len_r;
  logic [WINDOW_MAX-1:0]   bmap_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic                    adv_r;

  logic                    out_valid_r;
  logic                    out_kind_r;
  logic [SEQ_W-1:0]        out_ack_r;
  logic [WIN_W-1:0]        out_win_r;
  logic [PAY_PORT_W-1:0]   out_pay_r;
  logic                    out_last_r;

  logic [VAL_W-1:0]        src_ext;
  logic [SIDX_W-1:0]       sidx_in;
  logic [SIDX_W-1:0]       sidx_r;
  logic [VAL_W-1:0]        seq_mod;
  logic [VAL_W-1:0]        wnd_mod;
  logic [WSL_W-1:0]        res_slot;

  alu_req_t                req;
  alu_rsp_t                rsp;

  assign src_ext  = VAL_W'(src);
  assign sidx_in  = src_ext[SIDX_W-1:0];
  assign sidx_r   = SIDX_W'(VAL_W'(src_r));
  assign seq_mod  = VAL_W'(SEQ_SPACE);
  assign wnd_mod  = VAL_W'(wnd);
  assign res_slot = rsp.res[WSL_W-1:0];

  // shared modular unit
  srrw_modalu u_alu (
    .req (req),
    .rsp (rsp)
  );

  // operand selection for the shared unit
  always_comb begin
    req.op = ALU_ADD;
    req.a  = '0;
    req.b  = '0;
    req.m  = seq_mod;
    unique case (state_r)
      S_SEQRED: begin
        req.a = x_r;
      end
      S_LEN: begin
        req.op = ALU_SUB;
        req.a  = x_r;
        req.b  = VAL_W'(base_r);
      end
      S_BSRED: begin
        req.a = VAL_W'(p_r);
        req.m = wnd_mod;
      end
      S_POS: begin
        req.a = VAL_W'(p_r);
        req.b = VAL_W'(len_r);
        req.m = wnd_mod;
      end
      S_SCAN_OUT: begin
        req.a = VAL_W'(base_r);
        req.b = VAL_W'(1);
      end
      S_SCAN_NXT: begin
        req.a = VAL_W'(p_r);
        req.b = VAL_W'(1);
        req.m = wnd_mod;
      end
      S_ACK: begin
        req.op = ALU_SUB;
        req.a  = VAL_W'(base_r);
        req.b  = VAL_W'(1);
      end
      default: begin
        req.op = ALU_ADD;
      end
    endcase
  end

  // memory requests
  assign st_rd_en   = go;
  assign st_rd_addr = sidx_in;
  assign st_wr_en   = (state_r == S_WB);
  assign st_wr_addr = sidx_r;
  assign st_wr_data = {base_r, (adv_r ? p_r : bslot_r), bmap_r};

  assign sl_wr_en   = (state_r == S_POS);
  assign sl_wr_addr = {sidx_r, res_slot};
  assign sl_wr_data = pay_r;
  assign sl_rd_en   = (state_r == S_SCAN_RD) && bmap_r[p_r];
  assign sl_rd_addr = {sidx_r, p_r};

  assign busy = (state_r != S_IDLE);

  // sequencer and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_SCAN_OUT) || (state_r == S_ACK);
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            src_r   <= src;
            x_r     <= VAL_W'(seq);
            pay_r   <= pay;
            state_r <= S_SEQRED;
          end
        end
        // sequence number modulo the sequence space, one subtract a cycle
        S_SEQRED: begin
          x_r <= rsp.res;
          if (!rsp.wrap) begin
            base_r  <= st_rd_data[ST_W-1 -: SEQ_W];
            bslot_r <= st_rd_data[WINDOW_MAX +: WSL_W];
            bmap_r  <= st_rd_data[WINDOW_MAX-1:0];
            state_r <= S_LEN;
          end
        end
        // distance from the window base
        S_LEN: begin
          len_r <= rsp.res[SEQ_W-1:0];
          p_r   <= bslot_r;
          adv_r <= 1'b0;
          if (rsp.res < wnd_mod) begin
            state_r <= S_BSRED;
          end else begin
            state_r <= S_ACK;
          end
        end
        // base slot modulo the window size
        S_BSRED: begin
          p_r <= res_slot;
          if (!rsp.wrap) begin
            state_r <= S_POS;
          end
        end
        // store the payload and mark its slot
        S_POS: begin
          bmap_r[res_slot] <= 1'b1;
          if (len_r == '0) begin
            adv_r   <= 1'b1;
            state_r <= S_SCAN_RD;
          end else begin
            state_r <= S_WB;
          end
        end
        // release contiguous slots from the base
        S_SCAN_RD: begin
          if (bmap_r[p_r]) begin
            state_r <= S_SCAN_OUT;
          end else begin
            state_r <= S_WB;
          end
        end
        S_SCAN_OUT: begin
          out_kind_r       <= KIND_DELIVERY;
          out_ack_r        <= '0;
          out_win_r        <= '0;
          out_pay_r        <= PAY_PORT_W'(sl_rd_data);
          out_last_r       <= 1'b0;
          bmap_r[p_r]      <= 1'b0;
          base_r           <= rsp.res[SEQ_W-1:0];
          state_r          <= S_SCAN_NXT;
        end
        S_SCAN_NXT: begin
          p_r     <= res_slot;
          state_r <= S_SCAN_RD;
        end
        S_WB: begin
          state_r <= S_ACK;
        end
        // cumulative ack closes the run
        S_ACK: begin
          out_kind_r  <= KIND_ACK;
          out_ack_r   <= rsp.res[SEQ_W-1:0];
          out_win_r   <= wnd;
          out_pay_r   <= '0;
          out_last_r  <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = out_kind_r;
  assign out_peer_id           = src_r;
  assign out_ack_number        = out_ack_r;
  assign out_advertised_window = out_win_r;
  assign out_delivered_payload = out_pay_r;
  assign out_last_of_run       = out_last_r;

endmodule

FILE: hdl/selective_repeat_receiver_window_core.sv
// selective-repeat receiver with one receive window per sender
//
//   channel   handshake           payload
//   frame     start / busy        in_source_id in_dest_id in_seq_number
//                                 in_check_failed in_payload_word
//   result    out_valid strobe    out_result_kind out_peer_id out_ack_number
//                                 out_advertised_window out_delivered_payload
//                                 out_last_of_run
//   config    cfg_we              cfg_index cfg_wdata
//
// a frame is taken when start is high and busy is low; a dropped frame leaves
// busy low. a kept frame holds busy while its seq is reduced and its distance from
// the base checked; outside the window it acks, else it reduces the base slot, stores
// the payload, releases contiguous payloads at the base, writes back state and acks.
// each result is shown for one cycle; the receiver cannot stall it.
// synchronous active-low reset clears all window state at once.
module selective_repeat_receiver_window_core
  import srrw_pkg::*;
#(
  parameter int SENDERS      = 16,
  parameter int SEQ_SPACE    = 256,
  parameter int WINDOW_MAX   = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // frame transaction
  input  logic                  start,
  output logic                  busy,
  input  logic [PEER_W-1:0]     in_source_id,
  input  logic [DEST_W-1:0]     in_dest_id,
  input  logic [SEQ_W-1:0]      in_seq_number,
  input  logic                  in_check_failed,
  input  logic [PAY_PORT_W-1:0] in_payload_word,
  // result transaction
  output logic                  out_valid,
  output logic                  out_result_kind,
  output logic [PEER_W-1:0]     out_peer_id,
  output logic [SEQ_W-1:0]      out_ack_number,
  output logic [WIN_W-1:0]      out_advertised_window,
  output logic [PAY_PORT_W-1:0] out_delivered_payload,
  output logic                  out_last_of_run,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SIDX_W = (SENDERS > 1) ? $clog2(SENDERS) : 1;
  localparam int WSL_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int ST_W   = SEQ_W + WSL_W + WINDOW_MAX;

  logic [DEST_W-1:0]       rid_r;
  logic [WIN_W-1:0]        wslots_r;
  logic [WIN_W-1:0]        wnd_eff;
  logic                    frame_ok;
  logic                    go;

  logic                    st_rd_en;
  logic [SIDX_W-1:0]       st_rd_addr;
  logic [ST_W-1:0]         st_rd_data;
  logic                    st_wr_en;
  logic [SIDX_W-1:0]       st_wr_addr;
  logic [ST_W-1:0]         st_wr_data;
  logic                    sl_rd_en;
  logic [SIDX_W+WSL_W-1:0] sl_rd_addr;
  logic [PAYLOAD_BITS-1:0] sl_rd_data;
  logic                    sl_wr_en;
  logic [SIDX_W+WSL_W-1:0] sl_wr_addr;
  logic [PAYLOAD_BITS-1:0] sl_wr_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rid_r    <= '0;
      wslots_r <= WINDOW_SLOTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RECEIVER_ID:  rid_r    <= cfg_wdata;
        REG_WINDOW_SLOTS: wslots_r <= cfg_wdata[WIN_W-1:0];
        default:          rid_r    <= rid_r;
      endcase
    end
  end

  // window size clamped to one .. WINDOW_MAX
  always_comb begin
    if (wslots_r == '0) begin
      wnd_eff = WIN_W'(1);
    end else if (wslots_r > WIN_W'(WINDOW_MAX)) begin
      wnd_eff = WIN_W'(WINDOW_MAX);
    end else begin
      wnd_eff = wslots_r;
    end
  end

  // frame filter: good check, our address, known sender
  assign frame_ok = !in_check_failed && (in_dest_id == rid_r) &&
                    (VAL_W'(in_source_id) < VAL_W'(SENDERS));
  assign go = start && !busy && frame_ok;

  srrw_ctrl #(
    .SEQ_SPACE    (SEQ_SPACE),
    .WINDOW_MAX   (WINDOW_MAX),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SIDX_W       (SIDX_W),
    .WSL_W        (WSL_W)
  ) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .go                    (go),
    .src                   (in_source_id),
    .seq                   (in_seq_number),
    .pay                   (in_payload_word[PAYLOAD_BITS-1:0]),
    .wnd                   (wnd_eff),
    .busy                  (busy),
    .st_rd_en              (st_rd_en),
    .st_rd_addr            (st_rd_addr),
    .st_rd_data            (st_rd_data),
    .st_wr_en              (st_wr_en),
    .st_wr_addr            (st_wr_addr),
    .st_wr_data            (st_wr_data),
    .sl_rd_en              (sl_rd_en),
    .sl_rd_addr            (sl_rd_addr),
    .sl_rd_data            (sl_rd_data),
    .sl_wr_en              (sl_wr_en),
    .sl_wr_addr            (sl_wr_addr),
    .sl_wr_data            (sl_wr_data),
    .out_valid             (out_valid),
    .out_result_kind       (out_result_kind),
    .out_peer_id           (out_peer_id),
    .out_ack_number        (out_ack_number),
    .out_advertised_window (out_advertised_window),
    .out_delivered_payload (out_delivered_payload),
    .out_last_of_run       (out_last_of_run)
  );

  srrw_state_ram #(
    .DEPTH (SENDERS),
    .AW    (SIDX_W),
    .DW    (ST_W)
  ) u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  srrw_slot_ram #(
    .AW (SIDX_W + WSL_W),
    .DW (PAYLOAD_BITS)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (sl_rd_en),
    .rd_addr (sl_rd_addr),
    .rd_data (sl_rd_data),
    .wr_en   (sl_wr_en),
    .wr_addr (sl_wr_addr),
    .wr_data (sl_wr_data)
  );

  // the ack closes a run and the sequencer is idle by then
  a_ack_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_result_kind == KIND_ACK && !busy)
    else $error("ack result shown while sequencer still busy");

  // a delivery never closes the run and always leaves the block busy
  a_delivery_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_DELIVERY |-> !out_last_of_run && busy)
    else $error("delivery result outside a running frame");

  // no result in the cycle after a frame is taken
  a_no_result_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("result right after a frame was taken");

  // a dropped frame never raises busy
  a_drop_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !frame_ok |=> !busy)
    else $error("dropped frame started the sequencer");

endmodule
